// ===== rtl/core/erbd_pkg.sv =====
// Shared types and constants for the escape run-length block decoder.
// No dependencies; imported by escape_rle_block_decoder.
`default_nettype none

package erbd_pkg;

  // Field widths
  localparam int unsigned AddrW  = 18;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;

  // Escape byte of the compressed stream
  localparam logic [ByteW-1:0] EscByte = 8'hED;

  // Register reset values
  localparam logic [AddrW-1:0] StartAddrRst = 18'h04000;
  localparam logic [LenW-1:0]  BlockLenRst  = 16'h4000;

  // Configuration register indexes
  localparam logic CfgStartAddr = 1'b0;
  localparam logic CfgBlockLen  = 1'b1;

  // Request kinds
  localparam logic KindByte  = 1'b0;
  localparam logic KindStart = 1'b1;

  // Input request: a source byte or a start of a new block
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] in_byte;
  } in_t;

  // One decoded run
  typedef struct packed {
    logic [AddrW-1:0] run_address;
    logic [ByteW-1:0] run_byte;
    logic [ByteW-1:0] run_length;
    logic             block_done;
    logic             ended_by_marker;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/escape_rle_block_decoder.sv =====
// Escape run-length block decoder: one compressed byte per request, runs out.
// Runs enter a 4-entry result queue when their request is accepted. Throughput: one
// request per cycle while the input is not stalled; runs leave one per cycle while the output is not stalled.
// A lone escape followed by a literal yields two runs (one if the escape ends the block);
// input stalls while the queue holds more than two runs. Reset: registers return to
// 0x4000, block finished, queue empty. Depends on erbd_pkg.
`default_nettype none

module escape_rle_block_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // source requests
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire erbd_pkg::in_t in_data_i,
  // decoded runs
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output erbd_pkg::out_t     out_data_o,
  // configuration writes
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_index_i,
  input  wire logic [17:0]   cfg_data_i
);
  import erbd_pkg::*;

  // Decode phases
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhOneEsc = 2'd1;
  localparam logic [1:0] PhTwoEsc = 2'd2;
  localparam logic [1:0] PhCount  = 2'd3;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration registers
  logic [AddrW-1:0] start_addr_q;
  logic [LenW-1:0]  block_len_q;

  // Decoder state
  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] pending_q, pending_d;
  logic [AddrW-1:0] waddr_q, waddr_d;
  logic [LenW-1:0]  left_q, left_d;
  logic             finished_q, finished_d;

  // Result queue
  out_t             q_mem [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic             in_acc, out_acc;
  out_t             res0, res1;
  logic [1:0]       push_n;
  logic [ByteW-1:0] b;
  logic [LenW-1:0]  left_one, left_two, left_run;
  logic [AddrW-1:0] waddr_one, waddr_two;
  logic [ByteW-1:0] run_len;

  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign b           = in_data_i.in_byte;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= StartAddrRst;
      block_len_q  <= BlockLenRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgStartAddr: start_addr_q <= cfg_data_i;
        CfgBlockLen:  block_len_q  <= cfg_data_i[LenW-1:0];
        default:      ;
      endcase
    end
  end

  // Arithmetic for single literals and clamped runs
  assign left_one  = left_q - LenW'(1);
  assign left_two  = left_q - LenW'(2);
  assign waddr_one = waddr_q + AddrW'(1);
  assign waddr_two = waddr_q + AddrW'(2);
  assign run_len   = (left_q < {{(LenW-ByteW){1'b0}}, pending_q}) ? left_q[ByteW-1:0]
                                                                  : pending_q;
  assign left_run  = left_q - {{(LenW-ByteW){1'b0}}, run_len};

  // Decode one request into up to two runs
  always_comb begin
    phase_d    = phase_q;
    pending_d  = pending_q;
    waddr_d    = waddr_q;
    left_d     = left_q;
    finished_d = finished_q;
    res0       = '0;
    res1       = '0;
    push_n     = 2'd0;
    if (in_acc) begin
      if (in_data_i.kind == KindStart) begin
        // start of a new block
        waddr_d    = start_addr_q;
        left_d     = block_len_q;
        phase_d    = PhIdle;
        pending_d  = '0;
        finished_d = (block_len_q == '0);
        if (block_len_q == '0) begin
          res0.run_address = start_addr_q;
          res0.block_done  = 1'b1;
          push_n           = 2'd1;
        end
      end else if (!finished_q) begin
        case (phase_q)
          PhIdle: begin
            if (b == EscByte) begin
              phase_d = PhOneEsc;
            end else begin
              res0.run_address = waddr_q;
              res0.run_byte    = b;
              res0.run_length  = ByteW'(1);
              res0.block_done  = (left_one == '0);
              push_n           = 2'd1;
              waddr_d          = waddr_one;
              left_d           = left_one;
              finished_d       = (left_one == '0);
            end
          end
          PhOneEsc: begin
            if (b == EscByte) begin
              phase_d = PhTwoEsc;
            end else begin
              // lone escape written literally, then this byte
              phase_d          = PhIdle;
              res0.run_address = waddr_q;
              res0.run_byte    = EscByte;
              res0.run_length  = ByteW'(1);
              res0.block_done  = (left_one == '0);
              if (left_one == '0) begin
                push_n     = 2'd1;
                waddr_d    = waddr_one;
                left_d     = left_one;
                finished_d = 1'b1;
              end else begin
                res1.run_address = waddr_one;
                res1.run_byte    = b;
                res1.run_length  = ByteW'(1);
                res1.block_done  = (left_two == '0);
                push_n           = 2'd2;
                waddr_d          = waddr_two;
                left_d           = left_two;
                finished_d       = (left_two == '0);
              end
            end
          end
          PhTwoEsc: begin
            if (b == '0) begin
              // end marker
              finished_d           = 1'b1;
              phase_d              = PhIdle;
              res0.run_address     = waddr_q;
              res0.block_done      = 1'b1;
              res0.ended_by_marker = 1'b1;
              push_n               = 2'd1;
            end else begin
              pending_d = b;
              phase_d   = PhCount;
            end
          end
          default: begin
            // value byte of a repeat run
            phase_d          = PhIdle;
            pending_d        = '0;
            res0.run_address = waddr_q;
            res0.run_byte    = b;
            res0.run_length  = run_len;
            res0.block_done  = (left_run == '0);
            push_n           = 2'd1;
            waddr_d          = waddr_q + {{(AddrW-ByteW){1'b0}}, run_len};
            left_d           = left_run;
            finished_d       = (left_run == '0);
          end
        endcase
      end
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      pending_q  <= '0;
      waddr_q    <= '0;
      left_q     <= '0;
      finished_q <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      pending_q  <= pending_d;
      waddr_q    <= waddr_d;
      left_q     <= left_d;
      finished_q <= finished_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      q_mem[wptr_q + QPtrW'(1)] <= res1;
    end
  end

  // Result queue pointers and fill
  assign cnt_d = cnt_q + QCntW'(push_n) - QCntW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QPtrW'(push_n);
      rptr_q <= rptr_q + QPtrW'(out_acc);
      cnt_q  <= cnt_d;
    end
  end

  // Stall while a two-run request might not fit
  assign in_stall_o  = (cnt_q > QCntW'(QDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_mem[rptr_q];

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_done_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0 && (res0.block_done || (push_n == 2'd2 && res1.block_done)))
      |=> finished_q)
    else $error("finishing run did not close the block");

  a_open_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finished_q |-> left_q != '0)
    else $error("open block with no bytes left");

  a_idle_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> phase_q == PhIdle)
    else $error("escape phase held in finished block");

  a_two_runs_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> phase_q == PhOneEsc && res0.run_byte == EscByte)
    else $error("double run outside lone escape");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for escape_rle_block_decoder: sends compressed source requests,
// predicts every decoded run and compares it field by field at the output.
// Depends on erbd_pkg and the decoder RTL.
module tb_top;
  import erbd_pkg::*;

  typedef enum logic [1:0] {PhIdle, PhOneEsc, PhTwoEsc, PhCount} esc_phase_e;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1250;

  // DUT signals, all inputs known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = 1'b0;
  logic [AddrW-1:0] cfg_data_i  = '0;

  // Decoder state as predicted by the bench
  logic [AddrW-1:0] cfg_start_addr = StartAddrRst;
  logic [LenW-1:0]  cfg_block_len  = BlockLenRst;
  esc_phase_e       esc_phase      = PhIdle;
  logic [ByteW-1:0] held_count     = '0;
  logic [AddrW-1:0] next_addr      = '0;
  logic [LenW-1:0]  left_bytes     = '0;
  logic             block_over     = 1'b1;
  out_t             runs_due[$];

  int unsigned err_count    = 0;
  int unsigned runs_checked = 0;
  int unsigned useful_reqs  = 0;
  int unsigned blocks       = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_req     = 0;

  escape_rle_block_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Run prediction
  // ---------------------------------------------------------------------------

  // Queue one run clamped to the bytes left in the block
  task automatic emit_run(input logic [ByteW-1:0] value, input logic [ByteW-1:0] count);
    logic [LenW-1:0] len;
    out_t            run;
    len  = (LenW'(count) > left_bytes) ? left_bytes : LenW'(count);
    left_bytes = left_bytes - len;
    run.run_address     = next_addr;
    run.run_byte        = value;
    run.run_length      = len[ByteW-1:0];
    run.block_done      = (left_bytes == '0);
    run.ended_by_marker = 1'b0;
    runs_due.push_back(run);
    next_addr = next_addr + AddrW'(len);
    if (run.block_done) begin
      block_over = 1'b1;
      esc_phase  = PhIdle;
    end
  endtask

  // Advance the predicted state by one accepted request
  task automatic decode_request(input in_t req);
    out_t status;
    status = '0;
    if (req.kind == KindStart) begin
      next_addr  = cfg_start_addr;
      left_bytes = cfg_block_len;
      esc_phase  = PhIdle;
      held_count = '0;
      block_over = 1'b0;
      if (left_bytes == '0) begin
        block_over = 1'b1;
        status.run_address = next_addr;
        status.block_done  = 1'b1;
        runs_due.push_back(status);
      end
    end else if (!block_over) begin
      case (esc_phase)
        PhIdle: begin
          if (req.in_byte == EscByte) esc_phase = PhOneEsc;
          else emit_run(req.in_byte, 8'd1);
        end
        PhOneEsc: begin
          if (req.in_byte == EscByte) begin
            esc_phase = PhTwoEsc;
          end else begin
            // lone escape: literal ED, then this byte fresh unless block is used up
            esc_phase = PhIdle;
            emit_run(EscByte, 8'd1);
            if (!block_over) emit_run(req.in_byte, 8'd1);
          end
        end
        PhTwoEsc: begin
          if (req.in_byte == '0) begin
            // end marker
            block_over = 1'b1;
            esc_phase  = PhIdle;
            status.run_address     = next_addr;
            status.block_done      = 1'b1;
            status.ended_by_marker = 1'b1;
            runs_due.push_back(status);
          end else begin
            held_count = req.in_byte;
            esc_phase  = PhCount;
          end
        end
        default: begin
          esc_phase = PhIdle;
          emit_run(req.in_byte, held_count);
          held_count = '0;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic in_t src_byte(input logic [ByteW-1:0] b);
    return {KindByte, b};
  endfunction

  function automatic in_t start_req();
    return {KindStart, ByteW'($urandom)};
  endfunction

  // Offer one request and wait for it to be taken
  task automatic send_request(input in_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (req.kind == KindStart || !block_over) useful_reqs++;
    decode_request(req);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Bursts of random length, random gaps between them
  task automatic send_paced(input in_t req);
    send_request(req);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(30, 1);
      pause_input($urandom_range(6, 1));
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every predicted run has come out or the wait times out
  task automatic drain_runs();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [AddrW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CfgStartAddr) cfg_start_addr = data;
    else cfg_block_len = data[LenW-1:0];
  endtask

  // Both registers, written only once the decoder is idle
  task automatic configure(input logic [AddrW-1:0] addr, input logic [LenW-1:0] len);
    drain_runs();
    write_reg(CfgStartAddr, addr);
    write_reg(CfgBlockLen, {2'($urandom), len});
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall pattern with changing density, plus long hold-offs on request
  always @(posedge clk_i) begin
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned stall_pct;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(200, 20);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        pattern_left--;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Compare each accepted run with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (runs_due.size() == 0) begin
        $display("%0t: unexpected run, expected none, actual %p", $time, out_data_o);
        err_count++;
      end else begin
        want = runs_due.pop_front();
        check_field("run_address", 32'(want.run_address), 32'(out_data_o.run_address));
        check_field("run_byte", 32'(want.run_byte), 32'(out_data_o.run_byte));
        check_field("run_length", 32'(want.run_length), 32'(out_data_o.run_length));
        check_field("block_done", 32'(want.block_done), 32'(out_data_o.block_done));
        check_field("ended_by_marker", 32'(want.ended_by_marker),
                    32'(out_data_o.ended_by_marker));
        runs_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: bytes before start, literal extremes, a full run, lone ED, marker
  task automatic test_reset_values();
    send_paced(src_byte(8'h12));
    send_paced(start_req());
    blocks++;
    send_paced(src_byte(8'h00));
    send_paced(src_byte(8'hFF));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'hFF));
    send_paced(src_byte(8'h5A));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'h41));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'h00));
    send_paced(src_byte(8'h77));
  endtask

  // Zero length finishes at once with a status result
  task automatic test_zero_length();
    configure(AddrW'($urandom), '0);
    send_paced(start_req());
    blocks++;
    send_paced(src_byte(8'h33));
  endtask

  // Run across the address wrap, then a run clamped to the rest of the block
  task automatic test_clamp_and_wrap();
    configure(18'h3FFFF, 16'd300);
    send_paced(start_req());
    blocks++;
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'hFF));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'h80));
    send_paced(src_byte(8'h22));
  endtask

  // Start abandons a half-seen escape; a lone ED that fills the block drops the next byte
  task automatic test_lone_escape_at_end();
    configure('0, 16'd1);
    send_paced(start_req());
    send_paced(src_byte(EscByte));
    send_paced(src_byte(EscByte));
    send_paced(start_req());
    blocks += 2;
    send_paced(src_byte(EscByte));
    send_paced(src_byte(8'h33));
  endtask

  // Long output hold-off while requests keep coming, then wait for all runs
  task automatic test_backpressure();
    logic [ByteW-1:0] lit;
    configure(AddrW'($urandom), 16'hFFFF);
    send_request(start_req());
    blocks++;
    hold_req = 300;
    for (int i = 0; i < 80; i++) begin
      lit = ByteW'($urandom);
      if (lit == EscByte) lit = 8'h00;
      if (i % 3 != 2) send_request(src_byte(EscByte));
      send_request(src_byte(lit));
    end
    drain_runs();
  endtask

  // One random token of the compressed stream
  task automatic send_token();
    logic [ByteW-1:0] lit;
    logic [ByteW-1:0] cnt;
    lit = ByteW'($urandom);
    if (lit == EscByte) lit = ~lit;
    cnt = ByteW'($urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(255, 1));
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7: send_paced(src_byte(lit));
      8, 9, 10, 11, 12: begin
        send_paced(src_byte(EscByte));
        send_paced(src_byte(EscByte));
        send_paced(src_byte(cnt));
        send_paced(src_byte(ByteW'($urandom)));
      end
      13, 14: begin
        send_paced(src_byte(EscByte));
        send_paced(src_byte(lit));
      end
      15: begin
        send_paced(src_byte(EscByte));
        send_paced(src_byte(EscByte));
        send_paced(src_byte(8'h00));
      end
      16: begin
        send_paced(start_req());
        blocks++;
      end
      17: begin
        // broken escape cut off by a restart
        send_paced(src_byte(EscByte));
        send_paced(src_byte(EscByte));
        send_paced(src_byte(cnt));
        send_paced(start_req());
        blocks++;
      end
      default: send_paced(src_byte(ByteW'($urandom)));
    endcase
  endtask

  // Random blocks with random settings, tokens and trailing noise
  task automatic test_random_blocks();
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    int unsigned      tokens;
    int unsigned      goal;
    goal = useful_reqs + RandomItems;
    while (useful_reqs < goal) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       addr = '0;
          1:       addr = 18'h3FFFF;
          2:       addr = 18'h3FFFF - AddrW'($urandom_range(300));
          default: addr = AddrW'($urandom);
        endcase
        case ($urandom_range(7))
          0:       len = $urandom_range(1) ? 16'd0 : 16'd1;
          6:       len = LenW'($urandom_range(600, 65));
          7:       len = $urandom_range(1) ? 16'hFFFF : 16'd1;
          default: len = LenW'($urandom_range(64, 1));
        endcase
        configure(addr, len);
      end
      send_paced(start_req());
      blocks++;
      tokens = $urandom_range(40, 1);
      for (int t = 0; t < tokens && !block_over; t++) send_token();
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(4, 1)) send_paced(src_byte(ByteW'($urandom)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_zero_length();
    test_clamp_and_wrap();
    test_lone_escape_at_end();
    test_backpressure();
    test_random_blocks();
    drain_runs();
    if (runs_due.size() != 0) begin
      $display("%0t: %0d runs never came out, oldest expected %p", $time,
               runs_due.size(), runs_due[0]);
      err_count++;
    end
    $display("Checked %0d runs from %0d decoded requests over %0d blocks.",
             runs_checked, useful_reqs, blocks);
    $display("Covered literals, escaped runs, lone escapes, end markers, clamps, wrap, stalls.");
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("%0t: timeout, %0d runs still expected", $time, runs_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/erbd_pkg.sv
rtl/core/escape_rle_block_decoder.sv
bench/tb_top.sv
